// ----- rtl/core/qted_pkg.sv -----
// Package: shared constants, types and the CORDIC step-angle function for the quaternion unit.
package qted_pkg;

    // Default build parameters
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 15;

    // Field widths
    localparam int QUAT_W      = 16;
    localparam int PITCH_W     = 15;
    localparam int ANGLE_W     = 16;
    localparam int LIMIT_W     = 14;
    localparam int OPS_W       = 34;   // atan2 operands in Q.30
    localparam int CORDIC_W    = 56;   // prescaled vectoring datapath
    localparam int PRESCALE_SH = 20;
    localparam int SQRT_STEPS  = 31;   // one root bit per stage
    localparam int RAD_W       = 29;

    localparam logic [LIMIT_W-1:0] PITCH_LIMIT_RST = 14'd11392;
    localparam logic [ANGLE_W-1:0] PITCH_SAT       = 16'd11520;
    localparam logic [ANGLE_W-1:0] ANGLE_SAT       = 16'd23040;
    localparam logic [RAD_W-1:0]   RAD_TO_DEG128   = 29'd480631834;
    localparam longint             HALF_PI_Q30     = 64'sd1686629713;

    // Lane codes
    localparam int LANE_PITCH = 0;
    localparam int LANE_ROLL  = 1;
    localparam int LANE_YAW   = 2;
    localparam int LANES      = 3;

    localparam int TABLE_LEN = 24;
    localparam longint STEP_ANGLE_Q30 [TABLE_LEN] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // atan2 operand pairs for roll and yaw
    typedef struct packed {
        logic signed [OPS_W-1:0] rn;
        logic signed [OPS_W-1:0] rd;
        logic signed [OPS_W-1:0] yn;
        logic signed [OPS_W-1:0] yd;
    } atan_ops_t;

    // Move a Q30 angle to fb fraction bits, rounding half up
    function automatic longint q30_to_frac(input longint v, input int fb);
        int     sh;
        longint half;
        sh   = 30 - fb;
        half = (sh > 0) ? (64'sd1 <<< (sh - 1)) : 64'sd0;
        return (v + half) >>> sh;
    endfunction

    function automatic longint step_angle(input int i, input int fb);
        return q30_to_frac(STEP_ANGLE_Q30[i], fb);
    endfunction

endpackage

// ----- rtl/core/quaternion_to_euler_degrees_unit.sv -----
// Top level: pipelined quaternion to pitch/roll/yaw conversion in 1/128 degree units.
// The unit accepts one quaternion word per cycle and returns one angle word per word, in
// order. Every stage is registered and advances together: three stages form the products,
// the atan2 operands and the clamped asin argument with its square, 31 stages extract the
// pitch cosine one root bit at a time, one stage prepares three CORDIC lanes, CORDIC_STEPS
// stages run the vectoring steps of all three lanes side by side, and two stages scale
// radians to degrees and saturate. The output register holds a word until taken; upstream
// stalls only while that word waits. pitch_limit is written through cfg_we/cfg_wdata and
// is compared at the output stage.
module quaternion_to_euler_degrees_unit #(
    parameter int CORDIC_STEPS = qted_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = qted_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [qted_pkg::LIMIT_W-1:0]          cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [qted_pkg::QUAT_W-1:0]    s_quat_w,
    input  logic signed [qted_pkg::QUAT_W-1:0]    s_quat_x,
    input  logic signed [qted_pkg::QUAT_W-1:0]    s_quat_y,
    input  logic signed [qted_pkg::QUAT_W-1:0]    s_quat_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [qted_pkg::PITCH_W-1:0]   m_pitch_deg,
    output logic signed [qted_pkg::ANGLE_W-1:0]   m_roll_deg,
    output logic signed [qted_pkg::ANGLE_W-1:0]   m_yaw_deg,
    output logic                                  m_angles_ok
);
    import qted_pkg::*;

    localparam int NST   = CORDIC_STEPS;
    localparam int SQ    = SQRT_STEPS;
    localparam int W     = CORDIC_W;
    localparam int ZW    = FRAC_BITS + 3;
    localparam int MW    = FRAC_BITS + 2;
    localparam int PW    = MW + RAD_W;
    localparam int SH    = FRAC_BITS + 16;
    localparam int LAT   = 3 + SQ + 1 + NST + 2;
    localparam int RW    = 62;

    logic en;
    logic [LAT-1:0] valid_reg;
    logic [LIMIT_W-1:0] pitch_limit_reg;

    // Advance the whole pipe unless the output word is waiting
    assign en      = !valid_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[LAT-1];

    // Hold the gimbal lock threshold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_limit_reg <= PITCH_LIMIT_RST;
        end else if (cfg_we) begin
            pitch_limit_reg <= cfg_wdata;
        end
    end

    // Shift valid bits along with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    // Stage 1: component products
    logic signed [31:0] p_wz_reg, p_xy_reg, p_zz_reg, p_xx_reg, p_wy_reg;
    logic signed [31:0] p_zx_reg, p_yy_reg, p_wx_reg, p_yz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_wz_reg <= 32'(s_quat_w) * 32'(s_quat_z);
            p_xy_reg <= 32'(s_quat_x) * 32'(s_quat_y);
            p_zz_reg <= 32'(s_quat_z) * 32'(s_quat_z);
            p_xx_reg <= 32'(s_quat_x) * 32'(s_quat_x);
            p_wy_reg <= 32'(s_quat_w) * 32'(s_quat_y);
            p_zx_reg <= 32'(s_quat_z) * 32'(s_quat_x);
            p_yy_reg <= 32'(s_quat_y) * 32'(s_quat_y);
            p_wx_reg <= 32'(s_quat_w) * 32'(s_quat_x);
            p_yz_reg <= 32'(s_quat_y) * 32'(s_quat_z);
        end
    end

    // Stage 2: atan2 operands and clamped asin argument
    localparam logic signed [OPS_W-1:0] ONE_Q30 = 34'sh0_4000_0000;

    atan_ops_t          ops2_reg, ops2_next;
    logic signed [31:0] s2_reg, s2_next;
    logic signed [OPS_W-1:0] s_full;

    always_comb begin
        ops2_next.rn = (34'(p_wz_reg) + 34'(p_xy_reg)) <<< 1;
        ops2_next.rd = ONE_Q30 - ((34'(p_zz_reg) + 34'(p_xx_reg)) <<< 1);
        ops2_next.yn = (34'(p_wy_reg) + 34'(p_zx_reg)) <<< 1;
        ops2_next.yd = ONE_Q30 - ((34'(p_xx_reg) + 34'(p_yy_reg)) <<< 1);
        s_full       = (34'(p_wx_reg) - 34'(p_yz_reg)) <<< 1;
        if (s_full > ONE_Q30) begin
            s2_next = 32'(ONE_Q30);
        end else if (s_full < -ONE_Q30) begin
            s2_next = 32'(-ONE_Q30);
        end else begin
            s2_next = 32'(s_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ops2_reg <= ops2_next;
            s2_reg   <= s2_next;
        end
    end

    // Stage 3 and square root pipe: radicand 2^60 - s^2, one root bit per stage
    logic [RW-1:0]      sq_rem_reg  [0:SQ];
    logic [RW-1:0]      sq_root_reg [0:SQ];
    logic [RW-1:0]      sq_rem_next [1:SQ];
    logic [RW-1:0]      sq_root_next[1:SQ];
    atan_ops_t          ops_d_reg   [0:SQ];
    logic signed [31:0] s_d_reg     [0:SQ];
    logic [30:0]        s_abs;
    logic [RW-1:0]      s_sq;

    always_comb begin
        s_abs = (s2_reg < 0) ? 31'(-s2_reg) : 31'(s2_reg);
        s_sq  = RW'(s_abs) * RW'(s_abs);
    end

    always_comb begin
        logic [RW-1:0] bitv;
        logic [RW-1:0] trial;
        for (int j = 0; j < SQ; j++) begin
            bitv  = RW'(1) << (60 - 2 * j);
            trial = sq_root_reg[j] + bitv;
            if (sq_rem_reg[j] >= trial) begin
                sq_rem_next[j+1]  = sq_rem_reg[j] - trial;
                sq_root_next[j+1] = (sq_root_reg[j] >> 1) + bitv;
            end else begin
                sq_rem_next[j+1]  = sq_rem_reg[j];
                sq_root_next[j+1] = sq_root_reg[j] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]  <= (RW'(1) << 60) - s_sq;
            sq_root_reg[0] <= '0;
            ops_d_reg[0]   <= ops2_reg;
            s_d_reg[0]     <= s2_reg;
            for (int j = 1; j <= SQ; j++) begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
                ops_d_reg[j]   <= ops_d_reg[j-1];
                s_d_reg[j]     <= s_d_reg[j-1];
            end
        end
    end

    // CORDIC lanes: pitch, roll, yaw
    logic signed [W-1:0]  cx_reg [0:NST][0:LANES-1];
    logic signed [W-1:0]  cy_reg [0:NST][0:LANES-1];
    logic signed [ZW-1:0] cz_reg [0:NST][0:LANES-1];
    logic [LANES-1:0]     zf_reg [0:NST];

    logic signed [W-1:0]  cx_next [0:NST][0:LANES-1];
    logic signed [W-1:0]  cy_next [0:NST][0:LANES-1];
    logic signed [ZW-1:0] cz_next [0:NST][0:LANES-1];
    logic [LANES-1:0]     zf_next;

    logic signed [OPS_W-1:0] lane_y [0:LANES-1];
    logic signed [OPS_W-1:0] lane_x [0:LANES-1];

    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(q30_to_frac(HALF_PI_Q30, FRAC_BITS));

    // Prepare lanes: prescale, zero check, quarter turn for negative x
    always_comb begin
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        lane_y[LANE_PITCH] = 34'(s_d_reg[SQ]);
        lane_x[LANE_PITCH] = {3'b000, sq_root_reg[SQ][30:0]};
        lane_y[LANE_ROLL]  = ops_d_reg[SQ].rn;
        lane_x[LANE_ROLL]  = ops_d_reg[SQ].rd;
        lane_y[LANE_YAW]   = ops_d_reg[SQ].yn;
        lane_x[LANE_YAW]   = ops_d_reg[SQ].yd;
        for (int l = 0; l < LANES; l++) begin
            zf_next[l] = (lane_x[l] == '0) && (lane_y[l] == '0);
            px = W'(lane_x[l]) <<< PRESCALE_SH;
            py = W'(lane_y[l]) <<< PRESCALE_SH;
            if (px < 0) begin
                if (py >= 0) begin
                    cx_next[0][l] = py;
                    cy_next[0][l] = -px;
                    cz_next[0][l] = HALF_PI_Z;
                end else begin
                    cx_next[0][l] = -py;
                    cy_next[0][l] = px;
                    cz_next[0][l] = -HALF_PI_Z;
                end
            end else begin
                cx_next[0][l] = px;
                cy_next[0][l] = py;
                cz_next[0][l] = '0;
            end
        end

        // Vectoring steps: drive y toward zero
        for (int i = 0; i < NST; i++) begin
            for (int l = 0; l < LANES; l++) begin
                if (cy_reg[i][l] >= 0) begin
                    cx_next[i+1][l] = cx_reg[i][l] + (cy_reg[i][l] >>> i);
                    cy_next[i+1][l] = cy_reg[i][l] - (cx_reg[i][l] >>> i);
                    cz_next[i+1][l] = cz_reg[i][l] + ZW'(step_angle(i, FRAC_BITS));
                end else begin
                    cx_next[i+1][l] = cx_reg[i][l] - (cy_reg[i][l] >>> i);
                    cy_next[i+1][l] = cy_reg[i][l] + (cx_reg[i][l] >>> i);
                    cz_next[i+1][l] = cz_reg[i][l] - ZW'(step_angle(i, FRAC_BITS));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zf_reg[0] <= zf_next;
            for (int i = 1; i <= NST; i++) begin
                zf_reg[i] <= zf_reg[i-1];
            end
            for (int i = 0; i <= NST; i++) begin
                for (int l = 0; l < LANES; l++) begin
                    cx_reg[i][l] <= cx_next[i][l];
                    cy_reg[i][l] <= cy_next[i][l];
                    cz_reg[i][l] <= cz_next[i][l];
                end
            end
        end
    end

    // Stage A: magnitude times degree scale
    logic [PW-1:0] prod_reg [0:LANES-1];
    logic [LANES-1:0] neg_reg;

    always_ff @(posedge aclk) begin
        logic signed [ZW-1:0] zv;
        logic [MW-1:0]        mag;
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                zv = zf_reg[NST][l] ? '0 : cz_reg[NST][l];
                mag = (zv < 0) ? MW'(-zv) : MW'(zv);
                neg_reg[l]  <= (zv < 0);
                prod_reg[l] <= PW'(mag) * PW'(RAD_TO_DEG128);
            end
        end
    end

    // Stage B: round, saturate, restore sign, check pitch limit
    logic [ANGLE_W-1:0] deg_mag [0:LANES-1];
    logic signed [ANGLE_W-1:0] deg_val [0:LANES-1];

    always_comb begin
        logic [PW:0]        rsum;
        logic [ANGLE_W-1:0] d;
        logic [ANGLE_W-1:0] lim;
        for (int l = 0; l < LANES; l++) begin
            rsum = (PW+1)'(prod_reg[l]) + ((PW+1)'(1) << (SH - 1));
            d    = ANGLE_W'(rsum >> SH);
            lim  = (l == LANE_PITCH) ? PITCH_SAT : ANGLE_SAT;
            if (d > lim) begin
                d = lim;
            end
            deg_mag[l] = d;
            deg_val[l] = neg_reg[l] ? -$signed(d) : $signed(d);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_pitch_deg <= PITCH_W'(deg_val[LANE_PITCH]);
            m_roll_deg  <= deg_val[LANE_ROLL];
            m_yaw_deg   <= deg_val[LANE_YAW];
            m_angles_ok <= (deg_mag[LANE_PITCH] <= ANGLE_W'(pitch_limit_reg));
        end
    end

endmodule

// ----- rtl/core/qted_checker.sv -----
// Checker: port-level assertions for the quaternion unit, bound to the top level.
module qted_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_ready,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [qted_pkg::PITCH_W-1:0]   m_pitch_deg,
    input logic signed [qted_pkg::ANGLE_W-1:0]   m_roll_deg,
    input logic signed [qted_pkg::ANGLE_W-1:0]   m_yaw_deg,
    input logic                                  m_angles_ok
);
    import qted_pkg::*;

    // Drop output words on reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    // Take input whenever no word waits
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // Hold a stalled output word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pitch_deg) && $stable(m_roll_deg)
        && $stable(m_yaw_deg) && $stable(m_angles_ok))
        else $error("stalled output word changed");

    // Keep angles within saturation bounds
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_deg <= 15'sd11520) && (m_pitch_deg >= -15'sd11520)
        && (m_roll_deg <= 16'sd23040) && (m_roll_deg >= -16'sd23040)
        && (m_yaw_deg <= 16'sd23040) && (m_yaw_deg >= -16'sd23040))
        else $error("angle outside saturation range");

endmodule

bind quaternion_to_euler_degrees_unit qted_checker u_qted_checker (.*);

// ----- dv/quaternion_to_euler_degrees_unit_test.sv -----
// Testbench: streams quaternions through the Euler angle unit and checks every angle word.
`timescale 1ns / 1ps

module quaternion_to_euler_degrees_unit_test;
    import qted_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int FB          = FRAC_BITS_DEF;
    localparam int LATENCY     = 37 + STEPS;
    localparam int WATCHDOG    = 4000;

    typedef struct {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] yaw;
        logic                      ok;
    } angles_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [LIMIT_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [QUAT_W-1:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [PITCH_W-1:0] m_pitch_deg;
    logic signed [ANGLE_W-1:0] m_roll_deg, m_yaw_deg;
    logic m_angles_ok;

    angles_t expected_angles[$];
    logic [LIMIT_W-1:0] gimbal_limit = PITCH_LIMIT_RST;
    int error_count = 0;
    int idle_cycles = 0;
    bit allow_gaps = 1'b1;

    quaternion_to_euler_degrees_unit u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_quat_w(s_quat_w), .s_quat_x(s_quat_x), .s_quat_y(s_quat_y), .s_quat_z(s_quat_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pitch_deg(m_pitch_deg), .m_roll_deg(m_roll_deg), .m_yaw_deg(m_yaw_deg),
        .m_angles_ok(m_angles_ok)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Step angle moved to FB fraction bits, rounding half up
    function automatic longint frac_angle(input longint q30);
        return (q30 + (64'sd1 <<< (30 - FB - 1))) >>> (30 - FB);
    endfunction

    // Vectoring CORDIC atan2 in radians with FB fraction bits
    function automatic longint vector_angle(input longint num, input longint den);
        longint px, py, acc, t, xs, ys;
        if (num == 0 && den == 0) return 0;
        px = den * 1048576;
        py = num * 1048576;
        acc = 0;
        if (px < 0) begin
            t = px;
            if (py >= 0) begin
                px = py; py = -t; acc = frac_angle(HALF_PI_Q30);
            end else begin
                px = -py; py = t; acc = -frac_angle(HALF_PI_Q30);
            end
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = px >>> i;
            ys = py >>> i;
            if (py >= 0) begin
                px += ys; py -= xs; acc += frac_angle(STEP_ANGLE_Q30[i]);
            end else begin
                px -= ys; py += xs; acc -= frac_angle(STEP_ANGLE_Q30[i]);
            end
        end
        return acc;
    endfunction

    // Radians to 1/128 degree, round half away from zero, saturate
    function automatic longint rad_to_deg128(input longint rad, input longint sat);
        logic [127:0] mag, d;
        mag = (rad < 0) ? -rad : rad;
        d = (mag * 128'd480631834 + (128'd1 << (FB + 15))) >> (FB + 16);
        if (d > sat) d = sat;
        return (rad < 0) ? -longint'(d) : longint'(d);
    endfunction

    // Exact floor square root
    function automatic longint floor_sqrt(input longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic angles_t euler_from_quat(input longint w, input longint x,
                                                input longint y, input longint z);
        angles_t a;
        longint one, s, c, p, ap;
        one = 64'sd1 <<< 30;
        s = 2 * (w * x - y * z);
        if (s > one) s = one;
        if (s < -one) s = -one;
        c = floor_sqrt((64'sd1 <<< 60) - s * s);
        p = rad_to_deg128(vector_angle(s, c), 11520);
        a.pitch = PITCH_W'(p);
        a.roll = ANGLE_W'(rad_to_deg128(vector_angle(2 * (w * z + x * y),
                                                     one - 2 * (z * z + x * x)), 23040));
        a.yaw = ANGLE_W'(rad_to_deg128(vector_angle(2 * (w * y + z * x),
                                                    one - 2 * (x * x + y * y)), 23040));
        ap = (p < 0) ? -p : p;
        a.ok = (ap <= gimbal_limit);
        return a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one quaternion word and queue its expected angles
    task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_quat_w <= w; s_quat_x <= x; s_quat_y <= y; s_quat_z <= z;
        expected_angles.insert(expected_angles.size(), euler_from_quat(w, x, y, z));
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_and_idle();
        s_valid <= 1'b0;
        while (expected_angles.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain_and_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        gimbal_limit = v;
    endtask

    // Random unit quaternion, scaled to Q1.15
    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $urandom_range(0, 65535) - 32768.0;
        b = $urandom_range(0, 65535) - 32768.0;
        c = $urandom_range(0, 65535) - 32768.0;
        d = $urandom_range(0, 65535) - 32768.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
                  16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
    endtask

    task automatic test_extremes();
        send_quat(16'sh7FFF, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_quat(16'sh5A82, 16'sh5A82, 0, 0);      // pitch at +90
        send_quat(16'sh5A82, -16'sh5A82, 0, 0);     // pitch at -90
        send_quat(16'sh7FFF, 16'sh7FFF, 0, 0);      // asin argument beyond one
        send_quat(16'sh7FFF, -16'sh8000, 0, 0);
        send_quat(0, 0, 0, 16'sh7FFF);              // roll at 180
        send_quat(0, 0, 16'sh7FFF, 0);              // yaw at 180
        send_quat(0, 16'sh7FFF, 0, 0);
        send_quat(16'sh5A82, 0, 0, -16'sh5A82);
        send_quat(16'sh5A82, 0, -16'sh5A82, 0);
        send_quat(16'sh2000, 16'sh6000, -16'sh1000, 16'sh0800);
        send_quat(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        send_quat(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        send_quat(16'sh0001, 16'shFFFF, 16'sh0001, 16'shFFFF);
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_unit_quat();
        end
    endtask

    task automatic test_limit_settings();
        write_limit(14'd0);
        test_random_mix(80);
        write_limit(14'd11520);
        test_random_mix(80);
        write_limit(14'h3FFF);
        test_random_mix(60);
        write_limit(14'd5000);
        send_quat(16'sh5A82, 16'sh5A82, 0, 0);
        test_random_mix(80);
        write_limit(PITCH_LIMIT_RST);
    endtask

    // Random stalls on the result side
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (allow_gaps && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 16);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(negedge aclk);
        end
    end

    // Compare each accepted angle word with the oldest expectation
    always @(posedge aclk) begin
        angles_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected angle word", 1, 0);
            end else begin
                e = expected_angles.pop_front();
                if (m_pitch_deg !== e.pitch) report_mismatch("pitch", m_pitch_deg, e.pitch);
                if (m_roll_deg !== e.roll) report_mismatch("roll", m_roll_deg, e.roll);
                if (m_yaw_deg !== e.yaw) report_mismatch("yaw", m_yaw_deg, e.yaw);
                if (m_angles_ok !== e.ok) report_mismatch("angles_ok", m_angles_ok, e.ok);
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || expected_angles.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_extremes();
        test_limit_settings();
        test_random_mix(680);
        allow_gaps = 1'b0;
        test_random_mix(150);
        drain_and_idle();
        if (error_count == 0 && expected_angles.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
